### design/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation and status codes, default operand width, command/status structs.
// ----------------------------------------------------------------------------
package rau_pkg;
   localparam int OperandWidthDefault = 16;
   localparam int ResNumWidth = 32;
   localparam int ResDenWidth = 31;
   localparam int OpWidth = 3;
   localparam int StatusWidth = 2;

   localparam logic [OpWidth-1:0] OP_ADD = 3'd0;
   localparam logic [OpWidth-1:0] OP_SUB = 3'd1;
   localparam logic [OpWidth-1:0] OP_MUL = 3'd2;
   localparam logic [OpWidth-1:0] OP_DIV = 3'd3;
   localparam logic [OpWidth-1:0] OP_CMP = 3'd4;
   localparam logic [OpWidth-1:0] OP_INV = 3'd5;

   localparam logic [StatusWidth-1:0] ST_OK = 2'd0;
   localparam logic [StatusWidth-1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [StatusWidth-1:0] ST_DIV_ZERO = 2'd2;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,      // capture operands, split sign/magnitude
      CMD_GCD_A,     // start gcd for operand a
      CMD_GCD_B,
      CMD_GCD_R,
      CMD_COMBINE,   // capture reduced b
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctl_type;

   typedef struct packed {
      logic unit_busy;   // gcd/divide unit running
   } sts_type;
endpackage

### design/rau_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_req_if / rau_rsp_if: valid/ready channels
// Request carries two fractions and an operation; response a reduced fraction.
// ----------------------------------------------------------------------------
interface rau_req_if #(parameter int OPERAND_WIDTH = 16);
   logic valid;
   logic ready;
   logic [2:0] req_type;
   logic signed [OPERAND_WIDTH-1:0] a_numerator;
   logic signed [OPERAND_WIDTH-1:0] a_denominator;
   logic signed [OPERAND_WIDTH-1:0] b_numerator;
   logic signed [OPERAND_WIDTH-1:0] b_denominator;
   modport source(output valid, req_type, a_numerator, a_denominator, b_numerator,
                  b_denominator, input ready);
   modport sink(input valid, req_type, a_numerator, a_denominator, b_numerator,
                b_denominator, output ready);
endinterface

interface rau_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] res_numerator;
   logic [30:0] res_denominator;
   logic is_less;
   logic is_equal;
   logic [1:0] status;
   modport source(output valid, res_numerator, res_denominator, is_less, is_equal,
                  status, input ready);
   modport sink(input valid, res_numerator, res_denominator, is_less, is_equal,
                status, output ready);
endinterface

### design/rau_gcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_gcd: reduce a fraction to lowest terms
// Binary (Stein) gcd, one step a cycle, then restoring division of both
// magnitudes by the gcd, one quotient bit a cycle for each in parallel.
// ----------------------------------------------------------------------------
module rau_gcd #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         busy,
   output logic [W-1:0] num_out,
   output logic [W-1:0] den_out
);
   localparam int CW = $clog2(W + 1);

   typedef enum logic [1:0] {S_IDLE, S_GCD, S_DIV} state_type;

   state_type state_ff, state_in;
   logic [W-1:0] x_ff, x_in, y_ff, y_in;
   logic [CW-1:0] k_ff, k_in;        // common power of two
   logic [W-1:0] g_ff, g_in;
   logic [W-1:0] qn_ff, qn_in, qd_ff, qd_in;
   logic [W-1:0] rn_ff, rn_in, rd_ff, rd_in;
   logic [W-1:0] n0_ff, n0_in, d0_ff, d0_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0] trn, trd;

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; k_in = k_ff; g_in = g_ff;
      qn_in = qn_ff; qd_in = qd_ff; rn_in = rn_ff; rd_in = rd_ff;
      n0_in = n0_ff; d0_in = d0_ff; cnt_in = cnt_ff;
      trn = '0; trd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (num == '0 || den == '0) begin
                  qn_in = '0; qd_in = W'(1);
               end else begin
                  x_in = num; y_in = den; k_in = '0;
                  n0_in = num; d0_in = den;
                  state_in = S_GCD;
               end
            end
         end
         S_GCD: begin
            if (x_ff[0] == 1'b0 && y_ff[0] == 1'b0) begin
               x_in = x_ff >> 1; y_in = y_ff >> 1; k_in = k_ff + CW'(1);
            end else if (x_ff[0] == 1'b0) begin
               x_in = x_ff >> 1;
            end else if (y_ff[0] == 1'b0) begin
               y_in = y_ff >> 1;
            end else if (x_ff == y_ff) begin
               g_in = x_ff << k_ff;
               cnt_in = CW'(W);
               rn_in = '0; rd_in = '0; qn_in = n0_ff; qd_in = d0_ff;
               state_in = S_DIV;
            end else if (x_ff > y_ff) begin
               x_in = (x_ff - y_ff) >> 1;
            end else begin
               y_in = (y_ff - x_ff) >> 1;
            end
         end
         S_DIV: begin
            // qn/qd shift in quotient bits as dividend bits leave
            trn = {rn_ff, qn_ff[W-1]} - {1'b0, g_ff};
            trd = {rd_ff, qd_ff[W-1]} - {1'b0, g_ff};
            if (trn[W]) rn_in = {rn_ff[W-2:0], qn_ff[W-1]};
            else rn_in = trn[W-1:0];
            if (trd[W]) rd_in = {rd_ff[W-2:0], qd_ff[W-1]};
            else rd_in = trd[W-1:0];
            qn_in = {qn_ff[W-2:0], ~trn[W]};
            qd_in = {qd_ff[W-2:0], ~trd[W]};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      x_ff <= x_in; y_ff <= y_in; k_ff <= k_in; g_ff <= g_in;
      qn_ff <= qn_in; qd_ff <= qd_in; rn_ff <= rn_in; rd_ff <= rd_in;
      n0_ff <= n0_in; d0_ff <= d0_in; cnt_ff <= cnt_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign num_out = qn_ff;
   assign den_out = qd_ff;
endmodule

### design/rau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, multiplier and shared reduction unit
// Executes one controller command at a time; holds the result register.
// ----------------------------------------------------------------------------
module rau_datapath #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rau_pkg::ctl_type        ctl,
   output rau_pkg::sts_type        sts,
   input  logic [2:0]              op,
   input  logic [OPERAND_WIDTH-1:0] an, ad, bn, bd,
   output logic [31:0]             res_num,
   output logic [30:0]             res_den,
   output logic                    less,
   output logic                    equal,
   output logic [1:0]              status
);
   import rau_pkg::*;
   localparam int M = OPERAND_WIDTH;
   localparam int W = 2 * M + 2;

   logic zden;
   logic [M:0] ma_n_ff, ma_d_ff, mb_n_ff, mb_d_ff;   // magnitudes up to 2^(M-1)
   logic aneg_ff, bneg_ff;
   logic [2:0] op_ff;
   logic [1:0] st_ff;
   logic rneg_ff;
   logic less_ff, equal_ff;
   logic [W-1:0] g_num, g_den, gout_n, gout_d;
   logic gstart, gbusy;
   logic [2*M+1:0] p1, p2, p3;
   logic [W-1:0] sum_m;
   logic sum_neg, bneg_eff;
   logic [W-1:0] rn_ff, rd_ff;
   logic [63:0] gn_wide, gd_wide;
   logic [31:0] nsat;
   logic [30:0] dsat;

   function automatic logic [M:0] mag(input logic [M-1:0] v);
      logic [M:0] e;
      e = {v[M-1], v};
      return v[M-1] ? (M+1)'(-e) : e;
   endfunction

   assign zden = (ad == '0) || (op != OP_INV && bd == '0);

   rau_gcd #(.W(W)) u_gcd (
      .clock(clock), .reset(reset), .start(gstart), .num(g_num), .den(g_den),
      .busy(gbusy), .num_out(gout_n), .den_out(gout_d)
   );
   assign sts.unit_busy = gbusy;

   // products of the reduced operands
   assign p1 = ma_n_ff * mb_d_ff;
   assign p2 = mb_n_ff * ma_d_ff;
   assign p3 = (op_ff == OP_DIV) ? ma_n_ff * mb_d_ff : ma_n_ff * mb_n_ff;
   assign bneg_eff = (mb_n_ff == '0) ? 1'b0 :
                     ((op_ff == OP_SUB || op_ff == OP_CMP) ? ~bneg_ff : bneg_ff);

   always_comb begin
      if (aneg_ff == bneg_eff) begin
         sum_neg = aneg_ff; sum_m = W'(p1) + W'(p2);
      end else if (p1 >= p2) begin
         sum_neg = aneg_ff; sum_m = W'(p1 - p2);
      end else begin
         sum_neg = bneg_eff; sum_m = W'(p2 - p1);
      end
   end

   always_comb begin
      gstart = 1'b0; g_num = '0; g_den = '0;
      unique case (ctl.cmd)
         CMD_GCD_A: begin gstart = 1'b1; g_num = W'(ma_n_ff); g_den = W'(ma_d_ff); end
         CMD_GCD_B: begin gstart = 1'b1; g_num = W'(mb_n_ff); g_den = W'(mb_d_ff); end
         CMD_GCD_R: begin gstart = 1'b1; g_num = rn_ff; g_den = rd_ff; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_OK; less_ff <= 1'b0; equal_ff <= 1'b0;
      end else begin
         unique case (ctl.cmd)
            CMD_LOAD: begin
               op_ff <= op;
               ma_n_ff <= mag(an); ma_d_ff <= mag(ad);
               mb_n_ff <= mag(bn); mb_d_ff <= mag(bd);
               aneg_ff <= an[M-1] ^ ad[M-1];
               bneg_ff <= bn[M-1] ^ bd[M-1];
               st_ff <= zden ? ST_ZERO_DEN : ST_OK;
               less_ff <= 1'b0; equal_ff <= 1'b0;
            end
            CMD_GCD_A: ;
            CMD_GCD_B: begin
               // capture reduced a
               ma_n_ff <= gout_n[M:0]; ma_d_ff <= gout_d[M:0];
               if (gout_n == '0) aneg_ff <= 1'b0;
            end
            CMD_GCD_R: ;
            CMD_COMBINE: begin
               mb_n_ff <= gout_n[M:0]; mb_d_ff <= gout_d[M:0];
               if (gout_n == '0) bneg_ff <= 1'b0;
            end
            CMD_FINISH: begin
               // run after COMBINE: operands reduced, build raw result
               rneg_ff <= 1'b0; rn_ff <= '0; rd_ff <= W'(1);
               if (st_ff == ST_OK) begin
                  case (op_ff)
                     OP_ADD, OP_SUB: begin
                        rneg_ff <= sum_neg; rn_ff <= sum_m;
                        rd_ff <= W'(ma_d_ff) * W'(mb_d_ff);
                     end
                     OP_MUL: begin
                        rneg_ff <= aneg_ff ^ bneg_ff; rn_ff <= W'(p3);
                        rd_ff <= W'(ma_d_ff) * W'(mb_d_ff);
                     end
                     OP_DIV: begin
                        if (mb_n_ff == '0) st_ff <= ST_DIV_ZERO;
                        else begin
                           rneg_ff <= aneg_ff ^ bneg_ff; rn_ff <= W'(p3);
                           rd_ff <= W'(ma_d_ff) * W'(mb_n_ff);
                        end
                     end
                     OP_CMP: begin
                        equal_ff <= (sum_m == '0);
                        less_ff <= (sum_m != '0) && sum_neg;
                     end
                     OP_INV: begin
                        if (ma_n_ff == '0) st_ff <= ST_DIV_ZERO;
                        else begin
                           rneg_ff <= aneg_ff; rn_ff <= W'(ma_d_ff);
                           rd_ff <= W'(ma_n_ff);
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // saturate the reduced result (gout after the final gcd pass)
   assign gn_wide = 64'(gout_n);
   assign gd_wide = 64'(gout_d);

   always_comb begin
      if (rneg_ff && gn_wide != '0) begin
         nsat = (gn_wide > 64'h8000_0000) ? 32'h8000_0000 : 32'(-gn_wide[31:0]);
      end else begin
         nsat = (gn_wide > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : gn_wide[31:0];
      end
      dsat = (gd_wide > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : gd_wide[30:0];
   end

   assign res_num = nsat;
   assign res_den = dsat;
   assign less = less_ff;
   assign equal = equal_ff;
   assign status = st_ff;
endmodule

### design/rau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer for the rational arithmetic unit
// Load, reduce a, reduce b, combine, reduce result, hold response.
// ----------------------------------------------------------------------------
module rau_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rau_pkg::ctl_type ctl,
   input  rau_pkg::sts_type sts
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_GA, S_WA, S_GB, S_WB, S_COMB, S_FIN, S_GR, S_WR, S_OUT
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_GA;
            S_GA:   state_ff <= S_WA;
            S_WA:   if (!sts.unit_busy) state_ff <= S_GB;
            S_GB:   state_ff <= S_WB;
            S_WB:   if (!sts.unit_busy) state_ff <= S_COMB;
            S_COMB: state_ff <= S_FIN;
            S_FIN:  state_ff <= S_GR;
            S_GR:   state_ff <= S_WR;
            S_WR:   if (!sts.unit_busy) state_ff <= S_OUT;
            S_OUT:  if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      ctl.cmd = CMD_NONE;
      unique case (state_ff)
         S_IDLE: if (req_valid) ctl.cmd = CMD_LOAD;
         S_GA:   ctl.cmd = CMD_GCD_A;
         S_GB:   ctl.cmd = CMD_GCD_B;   // also captures reduced a
         S_COMB: ctl.cmd = CMD_COMBINE; // captures reduced b
         S_FIN:  ctl.cmd = CMD_FINISH;
         S_GR:   ctl.cmd = CMD_GCD_R;
         default: ctl.cmd = CMD_NONE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
endmodule

### design/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add/sub/mul/div/compare/invert
// Reduces operands and result to lowest terms with a shared gcd unit.
// ----------------------------------------------------------------------------
// channel | dir | fields
// req     | in  | req_type, a_/b_numerator, a_/b_denominator
// rsp     | out | res_numerator, res_denominator, is_less, is_equal, status
//
// One item at a time; three passes through the shared gcd/divide unit. Each
// pass runs the binary gcd steps, then divides both values by the gcd. Reset
// is synchronous and clears control and status flags. The result is held
// until rsp transfers; req is not ready again until then.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
   input logic clock,
   input logic reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);
   import rau_pkg::*;
   ctl_type ctl;
   sts_type sts;

   rau_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .ctl(ctl), .sts(sts)
   );

   rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts), .op(req.req_type),
      .an(req.a_numerator), .ad(req.a_denominator),
      .bn(req.b_numerator), .bd(req.b_denominator),
      .res_num(rsp.res_numerator), .res_den(rsp.res_denominator),
      .less(rsp.is_less), .equal(rsp.is_equal), .status(rsp.status)
   );
endmodule
